@@ hw/rtl/swss_pkg.sv @@
// Shared types, constants and the cotangent table of the wheel speed splitter.
package swss_pkg;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int ANG_W = 8;
  localparam int ABS_W = 7;
  localparam int CFG_W = 8;
  localparam int IDX_W = 2;

  // Factor format: unsigned Q1.FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int FACTOR_W = FRAC_BITS + 1;
  localparam int DIV_STEPS = FACTOR_W;

  // Radius format: unsigned Q16.16, cotangent in unsigned Q8.16
  localparam int COT_W = 24;
  localparam int MM_SHIFT = 16;
  localparam int R_W = COT_W + CFG_W;
  localparam int A_W = R_W + 1;

  // Speed product: signed speed times zero-extended factor
  localparam int PROD_W = SPEED_W + FACTOR_W + 1;

  // Servo map
  localparam int SNUM_W = 16;
  localparam int SQ_W = 8;
  localparam int SERVO_STEPS = SQ_W;
  localparam logic [SQ_W-1:0] SERVO_TOP = 8'd180;
  localparam logic [SQ_W-1:0] SERVO_MID = 8'd90;

  // Angle limits
  localparam int ANG_MAX = 90;
  localparam logic signed [ANG_W-1:0] ANG_HI = 8'sd90;
  localparam logic signed [ANG_W-1:0] ANG_LO = -8'sd90;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;

  // Register reset values
  localparam logic [CFG_W-1:0] TRACK_RESET = 8'd150;
  localparam logic [CFG_W-1:0] WHEELBASE_RESET = 8'd200;
  localparam logic [ABS_W-1:0] MAX_LEFT_RESET = 7'd45;
  localparam logic [ABS_W-1:0] MAX_RIGHT_RESET = 7'd45;

  typedef enum logic [IDX_W-1:0] {
    REG_TRACK_WIDTH = 2'd0,
    REG_WHEELBASE   = 2'd1,
    REG_MAX_LEFT    = 2'd2,
    REG_MAX_RIGHT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] track_width_mm;
    logic [CFG_W-1:0] wheelbase_mm;
    logic [ABS_W-1:0] max_left_deg;
    logic [ABS_W-1:0] max_right_deg;
  } cfg_t;

  // Per-item drive info carried down the pipe
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      neg;
    logic                      unity;
  } drv_t;

  // Cotangent table generation (elaboration only)
  localparam int ROM_DEPTH = ANG_MAX + 1;
  localparam int ANGLE_FRAC = 30;
  localparam int TAYLOR_TERMS = 12;
  localparam longint ONE_Q30 = 64'sd1 << ANGLE_FRAC;
  localparam longint unsigned PI_NUM = 64'd3141592653589793;
  localparam longint unsigned DEG_DEN = 64'd180 * 64'd1000000000000000;
  localparam longint unsigned Q816_MAX = 64'hFFFFFF;

  // Shift-subtract unsigned quotient
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed quotient truncated toward zero
  function automatic longint sdiv_tz(input longint a, input longint unsigned b);
    longint unsigned m;
    if (a < 0) begin
      m = $unsigned(-a);
      return -$signed(udiv64(m, b));
    end
    m = $unsigned(a);
    return $signed(udiv64(m, b));
  endfunction

  // floor(deg * pi / 180 * 2^30)
  function automatic longint deg_to_q30(input int deg);
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    int i;
    num = PI_NUM * 64'(deg);
    q = num / DEG_DEN;
    r = num % DEG_DEN;
    for (i = 0; i < ANGLE_FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEG_DEN) begin
        r = r - DEG_DEN;
        q = q | 64'd1;
      end
    end
    return $signed(q);
  endfunction

  function automatic logic [ROM_DEPTH*COT_W-1:0] build_cot_rom();
    logic [ROM_DEPTH*COT_W-1:0] rom;
    longint x;
    longint x2;
    longint s;
    longint st;
    longint c;
    longint ct;
    longint unsigned v;
    int deg;
    int n;
    rom = '0;
    rom[0 +: COT_W] = COT_W'(Q816_MAX);
    for (deg = 1; deg <= ANG_MAX; deg++) begin
      x = deg_to_q30(deg);
      x2 = x * x / ONE_Q30;
      s = x;
      st = x;
      c = ONE_Q30;
      ct = ONE_Q30;
      for (n = 1; n <= TAYLOR_TERMS; n++) begin
        st = sdiv_tz(-(st * x2 / ONE_Q30), 64'((2 * n) * (2 * n + 1)));
        s = s + st;
        ct = sdiv_tz(-(ct * x2 / ONE_Q30), 64'((2 * n - 1) * (2 * n)));
        c = c + ct;
      end
      if (c <= 0 || s <= 0 || deg == ANG_MAX) begin
        v = '0;
      end else begin
        v = udiv64(($unsigned(c) << 16) + ($unsigned(s) >> 1), $unsigned(s));
        if (v > Q816_MAX) v = Q816_MAX;
      end
      rom[deg*COT_W +: COT_W] = COT_W'(v);
    end
    return rom;
  endfunction

  // cot(deg) in Q8.16 for deg 0..90, packed low entry first
  localparam logic [ROM_DEPTH*COT_W-1:0] COT_ROM = build_cot_rom();

endpackage

@@ hw/rtl/steering_wheel_speed_split.sv @@
// Top level of the Ackermann rear wheel speed splitter with servo mapping.
// Each item (drive speed, steering angle) yields one result: both rear wheel
// speeds, the servo position and a span error flag. The block takes one item
// per clock when the output side is not stalled and passes it through 4 front
// stages (angle limit, cot table, radius multiply, radius adds), 18 divider
// stages (overflow check plus one quotient bit per stage for the 17-bit Q1.16
// factors), and 3 output stages (factor steering, multiply, truncate and
// saturate). Empty stages close up under a stall, so items keep entering
// while a result waits at the output. Configuration writes are taken every
// cycle and are read by the stages directly, so they also reach items in
// flight; write them only while no item is in flight.
module steering_wheel_speed_split (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swss_pkg::IDX_W-1:0]           cfg_index,
  input  logic [swss_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swss_pkg::SPEED_W-1:0]  drive_speed,
  input  logic signed [swss_pkg::ANG_W-1:0]    steer_deg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swss_pkg::SPEED_W-1:0]  left_speed,
  output logic signed [swss_pkg::SPEED_W-1:0]  right_speed,
  output logic [swss_pkg::SQ_W-1:0]            servo_pos,
  output logic                                 span_error
);

  swss_pkg::cfg_t cfg;

  logic                            f_valid, f_ready;
  swss_pkg::drv_t                  f_drv;
  logic [swss_pkg::A_W-1:0]        f_num_outer, f_num_inner, f_mid;
  logic [swss_pkg::SNUM_W-1:0]     f_servo_num;

  logic                            d_valid, d_ready;
  swss_pkg::drv_t                  d_drv;
  logic [swss_pkg::FACTOR_W-1:0]   d_factor_outer, d_factor_inner;
  logic [swss_pkg::SQ_W-1:0]       d_servo;
  logic                            d_span_err;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_width_mm <= swss_pkg::TRACK_RESET;
      cfg.wheelbase_mm   <= swss_pkg::WHEELBASE_RESET;
      cfg.max_left_deg   <= swss_pkg::MAX_LEFT_RESET;
      cfg.max_right_deg  <= swss_pkg::MAX_RIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (swss_pkg::cfg_reg_t'(cfg_index))
        swss_pkg::REG_TRACK_WIDTH: cfg.track_width_mm <= cfg_data;
        swss_pkg::REG_WHEELBASE:   cfg.wheelbase_mm   <= cfg_data;
        swss_pkg::REG_MAX_LEFT:    cfg.max_left_deg   <= cfg_data[swss_pkg::ABS_W-1:0];
        swss_pkg::REG_MAX_RIGHT:   cfg.max_right_deg  <= cfg_data[swss_pkg::ABS_W-1:0];
        default:                   cfg <= cfg;
      endcase
    end
  end

  swss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .drive_speed (drive_speed),
    .steer_deg   (steer_deg),
    .dn_valid    (f_valid),
    .dn_ready    (f_ready),
    .drv         (f_drv),
    .num_outer   (f_num_outer),
    .num_inner   (f_num_inner),
    .mid         (f_mid),
    .servo_num   (f_servo_num)
  );

  swss_fdiv u_fdiv (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up_valid     (f_valid),
    .up_ready     (f_ready),
    .drv          (f_drv),
    .num_outer    (f_num_outer),
    .num_inner    (f_num_inner),
    .mid          (f_mid),
    .servo_num    (f_servo_num),
    .dn_valid     (d_valid),
    .dn_ready     (d_ready),
    .drv_out      (d_drv),
    .factor_outer (d_factor_outer),
    .factor_inner (d_factor_inner),
    .servo        (d_servo),
    .span_err     (d_span_err)
  );

  swss_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (d_valid),
    .up_ready     (d_ready),
    .drv          (d_drv),
    .factor_outer (d_factor_outer),
    .factor_inner (d_factor_inner),
    .servo        (d_servo),
    .span_err     (d_span_err),
    .dn_valid     (out_valid),
    .dn_ready     (out_ready),
    .left_speed   (left_speed),
    .right_speed  (right_speed),
    .servo_pos    (servo_pos),
    .span_error   (span_error)
  );

`ifndef ASSERT_OFF
  // An open output slot must reach all the way back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output slot is free");

  // Zero span forces the servo to center
  a_span_center: assert property (@(posedge clk) disable iff (rst)
    (out_valid && span_error) |-> (servo_pos == swss_pkg::SERVO_MID))
    else $error("span error without centered servo");

  // Servo clamp holds on every delivered item
  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (servo_pos <= swss_pkg::SERVO_TOP))
    else $error("servo position above range");
`endif

endmodule

@@ hw/rtl/swss_front.sv @@
// Front pipe: angle limit, cotangent lookup, inner, middle and outer radius, servo numerator.
module swss_front (
  input  logic                             clk,
  input  logic                             rst,
  input  swss_pkg::cfg_t                   cfg,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [swss_pkg::SPEED_W-1:0] drive_speed,
  input  logic signed [swss_pkg::ANG_W-1:0]   steer_deg,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output swss_pkg::drv_t                   drv,
  output logic [swss_pkg::A_W-1:0]         num_outer,
  output logic [swss_pkg::A_W-1:0]         num_inner,
  output logic [swss_pkg::A_W-1:0]         mid,
  output logic [swss_pkg::SNUM_W-1:0]      servo_num
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [swss_pkg::ANG_W-1:0] ang_sat;
  logic [swss_pkg::ABS_W-1:0]        abs_next;
  logic signed [swss_pkg::ANG_W:0]   svt_next;

  swss_pkg::drv_t                    s1_drv, s2_drv, s3_drv;
  logic [swss_pkg::ABS_W-1:0]        s1_abs;
  logic signed [swss_pkg::ANG_W:0]   s1_svt;
  logic [swss_pkg::COT_W-1:0]        s2_cot, cot_next;
  logic [swss_pkg::SNUM_W-1:0]       s2_ns, s3_ns, ns_next;
  logic [swss_pkg::R_W-1:0]          s3_r, r_next;
  logic [swss_pkg::A_W-1:0]          mid_next, numo_next;

  // Advance a stage when it is empty or its content moves on
  assign en4 = !v4 || dn_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v4;

  // Limit the angle to +-90, split off sign and magnitude, add the left limit for the servo
  always_comb begin
    if (steer_deg > swss_pkg::ANG_HI) begin
      ang_sat = swss_pkg::ANG_HI;
    end else if (steer_deg < swss_pkg::ANG_LO) begin
      ang_sat = swss_pkg::ANG_LO;
    end else begin
      ang_sat = steer_deg;
    end
    abs_next = ang_sat[swss_pkg::ANG_W-1] ? swss_pkg::ABS_W'(-ang_sat)
                                          : ang_sat[swss_pkg::ABS_W-1:0];
    svt_next = $signed({ang_sat[swss_pkg::ANG_W-1], ang_sat})
             + $signed({2'b00, cfg.max_left_deg});
  end

  // Look up cot, form the servo numerator (zero when not positive)
  always_comb begin
    cot_next = swss_pkg::COT_ROM[32'(s1_abs) * swss_pkg::COT_W +: swss_pkg::COT_W];
    ns_next = (s1_svt > 9'sd0)
            ? swss_pkg::SNUM_W'(s1_svt[swss_pkg::ANG_W-1:0])
              * swss_pkg::SNUM_W'(swss_pkg::SERVO_TOP)
            : '0;
  end

  // Inner radius, then middle radius and outer numerator
  always_comb begin
    r_next = swss_pkg::R_W'(s2_cot) * swss_pkg::R_W'(cfg.wheelbase_mm);
    mid_next = {1'b0, s3_r}
             + swss_pkg::A_W'({cfg.track_width_mm[swss_pkg::CFG_W-1:1],
                               {swss_pkg::MM_SHIFT{1'b0}}});
    numo_next = {1'b0, s3_r}
              + swss_pkg::A_W'({cfg.track_width_mm, {swss_pkg::MM_SHIFT{1'b0}}});
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_drv <= '{speed: drive_speed, neg: ang_sat[swss_pkg::ANG_W-1],
                  unity: (ang_sat == '0)};
      s1_abs <= abs_next;
      s1_svt <= svt_next;
    end
    if (en2) begin
      s2_drv <= s1_drv;
      s2_cot <= cot_next;
      s2_ns  <= ns_next;
    end
    if (en3) begin
      s3_drv <= s2_drv;
      s3_r   <= r_next;
      s3_ns  <= s2_ns;
    end
    if (en4) begin
      drv       <= s3_drv;
      mid       <= mid_next;
      num_outer <= numo_next;
      num_inner <= {1'b0, s3_r};
      servo_num <= s3_ns;
    end
  end

endmodule

@@ hw/rtl/swss_fdiv.sv @@
// Pipelined restoring dividers: outer and inner factor, plus the servo map quotient.
module swss_fdiv (
  input  logic                              clk,
  input  logic                              rst,
  input  swss_pkg::cfg_t                    cfg,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  swss_pkg::drv_t                    drv,
  input  logic [swss_pkg::A_W-1:0]          num_outer,
  input  logic [swss_pkg::A_W-1:0]          num_inner,
  input  logic [swss_pkg::A_W-1:0]          mid,
  input  logic [swss_pkg::SNUM_W-1:0]       servo_num,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output swss_pkg::drv_t                    drv_out,
  output logic [swss_pkg::FACTOR_W-1:0]     factor_outer,
  output logic [swss_pkg::FACTOR_W-1:0]     factor_inner,
  output logic [swss_pkg::SQ_W-1:0]         servo,
  output logic                              span_err
);

  localparam int N = swss_pkg::DIV_STEPS;

  logic                            v    [0:N];
  logic                            en   [0:N];
  swss_pkg::drv_t                  sd   [0:N];
  logic [swss_pkg::A_W-1:0]        den  [0:N];
  logic [swss_pkg::A_W-1:0]        ro   [0:N];
  logic [swss_pkg::A_W-1:0]        ri   [0:N];
  logic [swss_pkg::FACTOR_W-1:0]   qo   [0:N];
  logic [swss_pkg::FACTOR_W-1:0]   qi   [0:N];
  logic                            sato [0:N];
  logic                            sati [0:N];
  logic [swss_pkg::SQ_W-1:0]       srem [0:N];
  logic [swss_pkg::SQ_W-1:0]       sbits[0:N];
  logic [swss_pkg::SQ_W-1:0]       sq   [0:N];
  logic                            ssat [0:N];
  logic                            serr [0:N];
  logic                            bo0, bi0;

  logic [swss_pkg::A_W:0]          to   [1:N];
  logic [swss_pkg::A_W:0]          ti   [1:N];
  logic                            geo  [1:N];
  logic                            gei  [1:N];
  logic [swss_pkg::SQ_W:0]         ts   [1:N];
  logic                            ges  [1:N];

  logic [swss_pkg::SQ_W-1:0]       span;
  logic [swss_pkg::A_W-1:0]        ho, hi;

  assign span = {1'b0, cfg.max_left_deg} + {1'b0, cfg.max_right_deg};
  assign ho = num_outer >> 1;
  assign hi = num_inner >> 1;

  // Ready chain from the last stage back to the entry
  always_comb begin
    en[N] = !v[N] || dn_ready;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign up_ready = en[0];
  assign dn_valid = v[N];

  // One quotient bit per stage; the low numerator bit enters at the first step
  always_comb begin
    for (int k = 1; k <= N; k++) begin
      to[k]  = {ro[k-1], (k == 1) ? bo0 : 1'b0};
      ti[k]  = {ri[k-1], (k == 1) ? bi0 : 1'b0};
      geo[k] = to[k] >= {1'b0, den[k-1]};
      gei[k] = ti[k] >= {1'b0, den[k-1]};
      ts[k]  = {srem[k-1], sbits[k-1][swss_pkg::SQ_W-1]};
      ges[k] = ts[k] >= {1'b0, span};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) v[k] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      for (int k = 1; k <= N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Entry: overflow checks and initial partial remainders
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sd[0]       <= '{speed: drv.speed, neg: drv.neg,
                       unity: drv.unity || (mid == '0)};
      den[0]      <= mid;
      ro[0]       <= ho;
      ri[0]       <= hi;
      sato[0]     <= ho >= mid;
      sati[0]     <= hi >= mid;
      bo0         <= num_outer[0];
      bi0         <= num_inner[0];
      qo[0]       <= '0;
      qi[0]       <= '0;
      srem[0]     <= servo_num[swss_pkg::SNUM_W-1:swss_pkg::SQ_W];
      sbits[0]    <= servo_num[swss_pkg::SQ_W-1:0];
      ssat[0]     <= servo_num[swss_pkg::SNUM_W-1:swss_pkg::SQ_W] >= span;
      serr[0]     <= span == '0;
      sq[0]       <= '0;
    end
  end

  // Division steps
  always_ff @(posedge clk) begin
    for (int k = 1; k <= N; k++) begin
      if (en[k]) begin
        sd[k]   <= sd[k-1];
        den[k]  <= den[k-1];
        sato[k] <= sato[k-1];
        sati[k] <= sati[k-1];
        ro[k]   <= geo[k] ? swss_pkg::A_W'(to[k] - {1'b0, den[k-1]})
                          : to[k][swss_pkg::A_W-1:0];
        ri[k]   <= gei[k] ? swss_pkg::A_W'(ti[k] - {1'b0, den[k-1]})
                          : ti[k][swss_pkg::A_W-1:0];
        qo[k]   <= {qo[k-1][swss_pkg::FACTOR_W-2:0], geo[k]};
        qi[k]   <= {qi[k-1][swss_pkg::FACTOR_W-2:0], gei[k]};
        ssat[k] <= ssat[k-1];
        serr[k] <= serr[k-1];
        if (k <= swss_pkg::SERVO_STEPS) begin
          srem[k]  <= ges[k] ? swss_pkg::SQ_W'(ts[k] - {1'b0, span})
                             : ts[k][swss_pkg::SQ_W-1:0];
          sbits[k] <= {sbits[k-1][swss_pkg::SQ_W-2:0], 1'b0};
          sq[k]    <= {sq[k-1][swss_pkg::SQ_W-2:0], ges[k]};
        end else begin
          srem[k]  <= srem[k-1];
          sbits[k] <= sbits[k-1];
          sq[k]    <= sq[k-1];
        end
      end
    end
  end

  // Apply unity, factor saturation, servo clamp and span error centering
  assign drv_out = sd[N];
  assign factor_outer = sd[N].unity ? swss_pkg::FACTOR_ONE
                      : (sato[N] ? swss_pkg::FACTOR_MAX : qo[N]);
  assign factor_inner = sd[N].unity ? swss_pkg::FACTOR_ONE
                      : (sati[N] ? swss_pkg::FACTOR_MAX : qi[N]);
  assign servo = serr[N] ? swss_pkg::SERVO_MID
               : ((ssat[N] || sq[N] > swss_pkg::SERVO_TOP) ? swss_pkg::SERVO_TOP
                                                           : sq[N]);
  assign span_err = serr[N];

endmodule

@@ hw/rtl/swss_scale.sv @@
// Output pipe: factor steering, speed multiply, truncation and saturation.
module swss_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  swss_pkg::drv_t                       drv,
  input  logic [swss_pkg::FACTOR_W-1:0]        factor_outer,
  input  logic [swss_pkg::FACTOR_W-1:0]        factor_inner,
  input  logic [swss_pkg::SQ_W-1:0]            servo,
  input  logic                                 span_err,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [swss_pkg::SPEED_W-1:0]  left_speed,
  output logic signed [swss_pkg::SPEED_W-1:0]  right_speed,
  output logic [swss_pkg::SQ_W-1:0]            servo_pos,
  output logic                                 span_error
);

  localparam logic signed [swss_pkg::PROD_W-1:0] BIAS =
    swss_pkg::PROD_W'((64'd1 << swss_pkg::FRAC_BITS) - 64'd1);
  localparam logic signed [swss_pkg::PROD_W-1:0] S16_MAX = 34'sd32767;
  localparam logic signed [swss_pkg::PROD_W-1:0] S16_MIN = -34'sd32768;

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic signed [swss_pkg::SPEED_W-1:0]  s1_speed;
  logic [swss_pkg::FACTOR_W-1:0]        s1_fl, s1_fr;
  logic [swss_pkg::SQ_W-1:0]            s1_servo, s2_servo;
  logic                                 s1_err, s2_err;
  logic signed [swss_pkg::PROD_W-1:0]   s2_pl, s2_pr, pl_next, pr_next;
  logic signed [swss_pkg::SPEED_W-1:0]  left_next, right_next;

  // Truncate toward zero after the fraction shift, then clamp to 16 bits
  function automatic logic signed [swss_pkg::SPEED_W-1:0] shift_sat(
    input logic signed [swss_pkg::PROD_W-1:0] p);
    logic signed [swss_pkg::PROD_W-1:0] adj;
    logic signed [swss_pkg::PROD_W-1:0] q;
    adj = p[swss_pkg::PROD_W-1] ? p + BIAS : p;
    q = adj >>> swss_pkg::FRAC_BITS;
    if (q > S16_MAX) return swss_pkg::SPEED_W'(S16_MAX);
    if (q < S16_MIN) return swss_pkg::SPEED_W'(S16_MIN);
    return q[swss_pkg::SPEED_W-1:0];
  endfunction

  assign en3 = !v3 || dn_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v3;

  // Both products in one stage, then truncation and saturation of the registered products
  always_comb begin
    pl_next = $signed({{(swss_pkg::PROD_W-swss_pkg::SPEED_W){s1_speed[swss_pkg::SPEED_W-1]}},
                       s1_speed})
            * $signed(swss_pkg::PROD_W'(s1_fl));
    pr_next = $signed({{(swss_pkg::PROD_W-swss_pkg::SPEED_W){s1_speed[swss_pkg::SPEED_W-1]}},
                       s1_speed})
            * $signed(swss_pkg::PROD_W'(s1_fr));
    left_next  = shift_sat(s2_pl);
    right_next = shift_sat(s2_pr);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Steer factors to wheels: a right turn speeds up the left wheel
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_speed <= drv.speed;
      s1_fl    <= drv.neg ? factor_inner : factor_outer;
      s1_fr    <= drv.neg ? factor_outer : factor_inner;
      s1_servo <= servo;
      s1_err   <= span_err;
    end
    if (en2) begin
      s2_pl    <= pl_next;
      s2_pr    <= pr_next;
      s2_servo <= s1_servo;
      s2_err   <= s1_err;
    end
    if (en3) begin
      left_speed  <= left_next;
      right_speed <= right_next;
      servo_pos   <= s2_servo;
      span_error  <= s2_err;
    end
  end

endmodule
